FILE: sv/pae_pkg.sv
// Shared types and constants for the particle frame-step update pipeline.
// Used by every module of the block; depends on nothing.
package pae_pkg;

    // Signed Q16.16 value
    typedef logic signed [31:0] fix_t;

    // Position and velocity of one particle, axis 0 = x
    typedef struct packed {
        fix_t [2:0] pos;
        fix_t [2:0] vel;
    } kin_t;

    // Per-stage control carried beside the data
    typedef struct packed {
        logic        alive;
        logic [24:0] new_age;
    } meta_t;

    // Configuration register indexes
    typedef enum logic [7:0] {
        REG_FRAME_STEP = 8'd0,
        REG_GRAVITY_X  = 8'd1,
        REG_GRAVITY_Y  = 8'd2,
        REG_GRAVITY_Z  = 8'd3,
        REG_STOP_ZERO  = 8'd4,
        REG_STOP_ONE   = 8'd5,
        REG_STOP_TWO   = 8'd6,
        REG_STOP_THREE = 8'd7
    } cfg_idx_t;

    localparam logic [23:0] FRAME_STEP_RST = 24'd1092;
    localparam int          DIV_STAGES     = 17;
    localparam logic [16:0] SEG_ONE        = 17'd21627;
    localparam logic [16:0] SEG_TWO        = 17'd43254;
    localparam logic [16:0] RATIO_MAX      = 17'd65536;

endpackage

FILE: sv/pae_move.sv
// Motion stages: gravity into velocity, trapezoid step into position.
// Four register stages; depends on pae_pkg.
module pae_move (
    input  logic             clk,
    input  logic             en,
    input  logic [23:0]      dt,
    input  pae_pkg::fix_t    grav [3],
    input  pae_pkg::kin_t    kin_in,
    output pae_pkg::kin_t    kin_out
);
    import pae_pkg::*;

    fix_t               p1_reg [3];
    fix_t               p2_reg [3];
    fix_t               p3_reg [3];
    fix_t               p4_reg [3];
    fix_t               v1_reg [3];
    fix_t               v2_reg [3];
    fix_t               v3_reg [3];
    fix_t               v4_reg [3];
    fix_t               vo_reg [3];
    logic signed [56:0] gp_reg [3];
    logic signed [57:0] sp_reg [3];

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        logic signed [32:0] sum;
        fix_t               nv;
        fix_t               np;

        // New velocity sits in v3_reg while the sum of old and new is formed
        assign nv  = $signed(v1_reg[a]) + $signed(gp_reg[a][47:16]);
        assign sum = {v2_reg[a][31], v2_reg[a]} + {v3_reg[a][31], v3_reg[a]};
        assign np  = $signed(p3_reg[a]) + $signed(sp_reg[a][48:17]);

        // Velocity stage holds the old velocity beside the new one
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                gp_reg[a] <= $signed(grav[a]) * $signed({1'b0, dt});
                p1_reg[a] <= $signed(kin_in.pos[a]);
                v1_reg[a] <= $signed(kin_in.vel[a]);
                p2_reg[a] <= p1_reg[a];
                v2_reg[a] <= v1_reg[a];
                v3_reg[a] <= nv;
                p3_reg[a] <= p2_reg[a];
                sp_reg[a] <= sum * $signed({1'b0, dt});
                vo_reg[a] <= v3_reg[a];
                p4_reg[a] <= np;
                v4_reg[a] <= vo_reg[a];
            end
        end

        assign kin_out.pos[a] = p4_reg[a];
        assign kin_out.vel[a] = v4_reg[a];
    end

endmodule

FILE: sv/pae_div.sv
// Pipelined restoring divider: ratio = floor(new_age * 2^16 / lifetime).
// One quotient bit per register stage; depends on pae_pkg.
module pae_div (
    input  logic        clk,
    input  logic        en,
    input  logic [24:0] new_age,
    input  logic [23:0] life,
    output logic [16:0] ratio
);
    import pae_pkg::*;

    logic [24:0] rem_reg  [DIV_STAGES];
    logic [16:0] quo_reg  [DIV_STAGES];
    logic [23:0] life_reg [DIV_STAGES];
    logic        lz_reg   [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        logic [24:0] rem_in;
        logic [16:0] quo_in;
        logic [23:0] life_in;
        logic        lz_in;
        logic        take;

        if (k == 0)
        begin : g_first
            assign rem_in  = new_age;
            assign quo_in  = '0;
            assign life_in = life;
            assign lz_in   = (life == '0);
        end
        else
        begin : g_next
            assign rem_in  = {rem_reg[k-1][23:0], 1'b0};
            assign quo_in  = quo_reg[k-1];
            assign life_in = life_reg[k-1];
            assign lz_in   = lz_reg[k-1];
        end

        assign take = (rem_in >= {1'b0, life_in});

        // Subtract the divisor where it fits and set one quotient bit
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= take ? (rem_in - {1'b0, life_in}) : rem_in;
                quo_reg[k]  <= quo_in | ({16'd0, take} << (DIV_STAGES - 1 - k));
                life_reg[k] <= life_in;
                lz_reg[k]   <= lz_in;
            end
        end
    end

    // Zero lifetime reads as ratio zero
    assign ratio = lz_reg[DIV_STAGES-1] ? '0 : quo_reg[DIV_STAGES-1];

endmodule

FILE: sv/pae_color.sv
// Color stages: segment select, interpolation multiply, add and saturate.
// Three register stages; depends on pae_pkg.
module pae_color (
    input  logic        clk,
    input  logic        en,
    input  logic [16:0] ratio,
    input  logic [23:0] stops [4],
    output logic [7:0]  chan [3]
);
    import pae_pkg::*;

    logic [16:0]        t_reg;
    logic [7:0]         ca1_reg [3];
    logic [7:0]         ca2_reg [3];
    logic signed [8:0]  dif_reg [3];
    logic signed [26:0] prd_reg [3];
    logic [7:0]         out_reg [3];
    logic [16:0]        seg_start;
    logic [23:0]        stop_a;
    logic [23:0]        stop_b;
    logic [16:0]        t_next;

    // Pick the segment by the age ratio
    always_comb
    begin
        if (ratio < SEG_ONE)
        begin
            seg_start = '0;
            stop_a    = stops[0];
            stop_b    = stops[1];
        end
        else if (ratio < SEG_TWO)
        begin
            seg_start = SEG_ONE;
            stop_a    = stops[1];
            stop_b    = stops[2];
        end
        else
        begin
            seg_start = SEG_TWO;
            stop_a    = stops[2];
            stop_b    = stops[3];
        end
        t_next = ((ratio - seg_start) << 1) + (ratio - seg_start);
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        localparam int SH = 16 - 8 * c;
        logic [7:0]         a_ch;
        logic [7:0]         b_ch;
        logic signed [11:0] sum;

        assign a_ch = stop_a[SH +: 8];
        assign b_ch = stop_b[SH +: 8];
        assign sum  = $signed({4'd0, ca2_reg[c]}) + $signed(prd_reg[c][26:16]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ca1_reg[c] <= a_ch;
                dif_reg[c] <= $signed({1'b0, b_ch}) - $signed({1'b0, a_ch});
                ca2_reg[c] <= ca1_reg[c];
                prd_reg[c] <= dif_reg[c] * $signed({1'b0, t_reg});
                if (sum < 0)
                    out_reg[c] <= '0;
                else if (sum > 12'sd255)
                    out_reg[c] <= 8'hFF;
                else
                    out_reg[c] <= sum[7:0];
            end
        end

        assign chan[c] = out_reg[c];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            t_reg <= t_next;
    end

endmodule

FILE: sv/particle_age_move_color_update.sv
// Top level of the particle frame-step update: config registers, pipeline
// control and output assembly. Depends on pae_pkg, pae_move, pae_div, pae_color.
//
// Usage:
//   s_* carries one particle per item (position, velocity, age, lifetime).
//   m_* returns one result per item (alive flag, new position, velocity,
//   age and interpolated color); a dead particle returns all zeros.
//   cfg_* writes frame step, gravity and the four color stops by index;
//   write only while no item is in flight. cfg_ready is always high.
// Timing:
//   An accepted item reaches m_tvalid through one entry
//   register, 17 divider stages (one quotient bit each for age/lifetime),
//   three color stages. Motion runs beside the divider and is delayed to match.
//   Throughput is one item per cycle while m_tready stays high.
// Reset and stall:
//   rst_n clears all valid bits and restores the register defaults.
//   When m_tready is low with a result waiting, the whole pipeline holds
//   and s_tready drops with it, even while earlier stages are empty.
module particle_age_move_color_update (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, age, lifetime
    input  logic [239:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // alive, new_pos_x/y/z, new_vel_x/y/z, new_age, color_red/green/blue, pad
    output logic [247:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import pae_pkg::*;

    localparam int LAST    = 20;
    localparam int MOVE_LAT = 4;
    localparam int KIN_DLY = LAST - MOVE_LAT;

    logic [23:0]  frame_step_reg;
    fix_t         grav_reg [3];
    logic [23:0]  stops_reg [4];
    logic         vld_reg [LAST+1];
    meta_t        meta_reg [LAST+1];
    kin_t         kin_in_reg;
    logic [23:0]  life_reg;
    kin_t         kin_mv;
    kin_t         kin_dly_reg [KIN_DLY];
    logic [16:0]  ratio;
    logic [7:0]   chan [3];
    logic         adv;
    logic [24:0]  age_sum;
    kin_t         kin_s;
    meta_t        out_meta;
    kin_t         out_kin;

    assign adv       = !vld_reg[LAST] || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign age_sum   = {1'b0, s_tdata[215:192]} + {1'b0, frame_step_reg};

    for (genvar a = 0; a < 3; a++)
    begin : g_unpack
        assign kin_s.pos[a] = s_tdata[32*a +: 32];
        assign kin_s.vel[a] = s_tdata[96 + 32*a +: 32];
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_step_reg <= FRAME_STEP_RST;
            grav_reg       <= '{default: '0};
            stops_reg      <= '{default: '0};
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FRAME_STEP: frame_step_reg <= cfg_data[23:0];
                REG_GRAVITY_X:  grav_reg[0]    <= cfg_data;
                REG_GRAVITY_Y:  grav_reg[1]    <= cfg_data;
                REG_GRAVITY_Z:  grav_reg[2]    <= cfg_data;
                REG_STOP_ZERO:  stops_reg[0]   <= cfg_data[23:0];
                REG_STOP_ONE:   stops_reg[1]   <= cfg_data[23:0];
                REG_STOP_TWO:   stops_reg[2]   <= cfg_data[23:0];
                REG_STOP_THREE: stops_reg[3]   <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '{default: 1'b0};
        else if (adv)
        begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i <= LAST; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // Capture the item, advance age and per-stage metadata
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kin_in_reg        <= kin_s;
            life_reg          <= s_tdata[239:216];
            meta_reg[0].new_age <= age_sum;
            meta_reg[0].alive <= (age_sum <= {1'b0, s_tdata[239:216]});
            for (int i = 1; i <= LAST; i++)
                meta_reg[i] <= meta_reg[i-1];
            kin_dly_reg[0] <= kin_mv;
            for (int i = 1; i < KIN_DLY; i++)
                kin_dly_reg[i] <= kin_dly_reg[i-1];
        end
    end

    pae_move u_move (
        .clk     (clk),
        .en      (adv),
        .dt      (frame_step_reg),
        .grav    (grav_reg),
        .kin_in  (kin_in_reg),
        .kin_out (kin_mv)
    );

    pae_div u_div (
        .clk     (clk),
        .en      (adv),
        .new_age (meta_reg[0].new_age),
        .life    (life_reg),
        .ratio   (ratio)
    );

    pae_color u_color (
        .clk   (clk),
        .en    (adv),
        .ratio (ratio),
        .stops (stops_reg),
        .chan  (chan)
    );

    // Assemble the result; dead particles read as zero
    assign out_meta = meta_reg[LAST];
    assign out_kin  = kin_dly_reg[KIN_DLY-1];
    assign m_tvalid = vld_reg[LAST];

    always_comb
    begin
        m_tdata = '0;
        if (out_meta.alive)
        begin
            m_tdata[0] = 1'b1;
            for (int a = 0; a < 3; a++)
            begin
                m_tdata[1 + 32*a +: 32]  = out_kin.pos[a];
                m_tdata[97 + 32*a +: 32] = out_kin.vel[a];
                m_tdata[217 + 8*a +: 8]  = chan[a];
            end
            m_tdata[216:193] = out_meta.new_age[23:0];
        end
    end

    // Stall gating matches the output side
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // Accepted item lands in the entry stage
    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted item lost at entry");

    // Live particle ratio never exceeds one
    a_ratio: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DIV_STAGES] && meta_reg[DIV_STAGES].alive |-> ratio <= RATIO_MAX)
        else $error("age ratio out of range");

    // Live result age never exceeds 24 bits
    a_age: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_meta.alive |-> !out_meta.new_age[24])
        else $error("live age overflow");

endmodule
